>>> rtl/iso8601_timestamp_to_epoch_core_macros.svh
// Assertion macros shared by the timestamp-to-epoch RTL.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ISO8601_TIMESTAMP_TO_EPOCH_CORE_MACROS_SVH
`define ISO8601_TIMESTAMP_TO_EPOCH_CORE_MACROS_SVH

// Condition holds at every edge outside reset
`define I2E_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define I2E_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent
`define I2E_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/i2e_pkg.sv
// Shared types, character codes and arithmetic constants for the timestamp parser.
// No dependencies.
package i2e_pkg;

   // Field positions while parsing
   localparam logic [2:0] FieldYear   = 3'd0;
   localparam logic [2:0] FieldMonth  = 3'd1;
   localparam logic [2:0] FieldDay    = 3'd2;
   localparam logic [2:0] FieldHour   = 3'd3;
   localparam logic [2:0] FieldMinute = 3'd4;
   localparam logic [2:0] FieldSecond = 3'd5;

   // Character codes
   localparam logic [7:0] CharNul   = 8'h00;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharT     = 8'h54;

   // Number accumulation and field limits
   localparam logic [11:0] AccMax    = 12'd4095;
   localparam logic [11:0] YearMin   = 12'd2020;
   localparam logic [11:0] YearMax   = 12'd2099;
   localparam logic [11:0] MonthMin  = 12'd1;
   localparam logic [11:0] MonthMax  = 12'd12;
   localparam logic [11:0] DayMin    = 12'd1;
   localparam logic [11:0] DayMax    = 12'd31;
   localparam logic [11:0] HourMax   = 12'd23;
   localparam logic [11:0] MinuteMax = 12'd59;
   localparam logic [11:0] SecondMax = 12'd60;

   // Days-from-civil constants
   localparam logic [7:0]  MarchDays      = 8'd153;
   localparam logic [8:0]  YearsPerEra    = 9'd400;
   localparam logic [17:0] DaysPerEra     = 18'd146097;
   localparam logic [8:0]  DaysPerYear    = 9'd365;
   localparam logic [19:0] DaysEpochShift = 20'd719468;
   localparam logic [16:0] SecPerDay      = 17'd86400;
   localparam logic [11:0] SecPerHour     = 12'd3600;
   localparam logic [5:0]  SecPerMin      = 6'd60;

   // Reciprocals for division by constants (exact over the operand ranges used)
   localparam logic [12:0] RecipEra     = 13'd5243;  // /400 for 12-bit years
   localparam int          EraShift     = 21;
   localparam logic [11:0] RecipFive    = 12'd3277;  // /5 for values below 2048
   localparam int          FiveShift    = 14;
   localparam logic [5:0]  RecipCentury = 6'd41;     // /100 for values below 400
   localparam int          CenturyShift = 12;

   // Queue depths
   localparam int MidDepthDefault = 2;
   localparam int OutDepthDefault = 8;

   // Parsed timestamp handed from parser to converter
   typedef struct packed {
      logic        ok;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } rec_type;

   // Finished result
   typedef struct packed {
      logic [31:0] epoch_seconds;
      logic        valid_res;
   } res_type;

   // Separator expected after each field
   function automatic logic [7:0] sep_char(logic [2:0] fidx);
      logic [7:0] c;
      unique case (fidx)
         FieldYear, FieldMonth:   c = CharMinus;
         FieldDay:                c = CharT;
         FieldHour, FieldMinute:  c = CharColon;
         default:                 c = CharNul;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/i2e_fifo.sv
// Small register-based queue used between parser and converter and at the result side.
// Depends on the assertion macro header only.
`include "iso8601_timestamp_to_epoch_core_macros.svh"

module i2e_fifo #(
   parameter int Width = 1,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty
);

   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [AddrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [AddrW-1:0] next_ptr(logic [AddrW-1:0] p);
      return (p == AddrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `I2E_ASSERT_ALWAYS(a_fifo_count_bound, clock, reset, count_ff <= CntW'(Depth), "fifo overfilled")

endmodule

>>> rtl/i2e_front.sv
// Character parser: one byte per cycle unless rec_full; emits a record on the last byte.
// Depends on i2e_pkg and the assertion macro header.
`include "iso8601_timestamp_to_epoch_core_macros.svh"

module i2e_front (
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      char_code,
   input  logic            last,
   input  logic            push,
   output logic            full,
   output logic            rec_push,
   output i2e_pkg::rec_type rec,
   input  logic            rec_full
);

   typedef struct packed {
      logic [2:0]  fidx;
      logic [11:0] acc;
      logic        minus;
      logic        sign_seen;
      logic        saw_digit;
      logic        failed;
      logic        finished;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } parse_type;

   parse_type parse_ff, parse_in;
   parse_type after_char, after_end;
   logic      accept;

   // Store the current number into its field and range check it
   function automatic parse_type commit(parse_type s);
      parse_type   r;
      logic [11:0] v, lo, hi;
      r = s;
      v = s.acc;
      if (s.minus && v != '0) r.failed = 1'b1;
      unique case (s.fidx)
         i2e_pkg::FieldYear: begin
            r.year = v;
            lo = i2e_pkg::YearMin;  hi = i2e_pkg::YearMax;
         end
         i2e_pkg::FieldMonth: begin
            r.month = v[3:0];
            lo = i2e_pkg::MonthMin; hi = i2e_pkg::MonthMax;
         end
         i2e_pkg::FieldDay: begin
            r.day = v[4:0];
            lo = i2e_pkg::DayMin;   hi = i2e_pkg::DayMax;
         end
         i2e_pkg::FieldHour: begin
            r.hour = v[4:0];
            lo = '0;                hi = i2e_pkg::HourMax;
         end
         i2e_pkg::FieldMinute: begin
            r.minute = v[5:0];
            lo = '0;                hi = i2e_pkg::MinuteMax;
         end
         i2e_pkg::FieldSecond: begin
            r.second = v[5:0];
            lo = '0;                hi = i2e_pkg::SecondMax;
         end
         default: begin
            r.failed = 1'b1;
            lo = '0;                hi = i2e_pkg::AccMax;
         end
      endcase
      if (v < lo || v > hi) r.failed = 1'b1;
      return r;
   endfunction

   // End of text: only a started seconds field may close here
   function automatic parse_type end_text(parse_type s);
      parse_type r;
      r = s;
      if (s.fidx == i2e_pkg::FieldSecond && s.saw_digit) begin
         r = commit(s);
         r.finished = 1'b1;
      end else begin
         r.failed = 1'b1;
      end
      return r;
   endfunction

   // Take one non-zero character
   function automatic parse_type consume(parse_type s, logic [7:0] c);
      parse_type   r;
      logic        digit, space;
      logic [15:0] n;
      r     = s;
      digit = (c >= i2e_pkg::CharZero) && (c <= i2e_pkg::CharNine);
      space = (c == i2e_pkg::CharSpace) || ((c >= i2e_pkg::CharTab) && (c <= i2e_pkg::CharCr));
      n     = 16'(s.acc) * 16'd10 + 16'(c[3:0]);
      if (s.saw_digit) begin
         if (digit) begin
            r.acc = (n > 16'(i2e_pkg::AccMax)) ? i2e_pkg::AccMax : n[11:0];
         end else begin
            r = commit(s);
            if (!r.failed) begin
               if (s.fidx == i2e_pkg::FieldSecond) begin
                  r.finished = 1'b1;
               end else if (c == i2e_pkg::sep_char(s.fidx)) begin
                  r.fidx      = s.fidx + 3'd1;
                  r.acc       = '0;
                  r.minus     = 1'b0;
                  r.sign_seen = 1'b0;
                  r.saw_digit = 1'b0;
               end else begin
                  r.failed = 1'b1;
               end
            end
         end
      end else if (digit) begin
         r.saw_digit = 1'b1;
         r.acc       = 12'(c[3:0]);
      end else if (s.sign_seen) begin
         r.failed = 1'b1;
      end else if (c == i2e_pkg::CharPlus || c == i2e_pkg::CharMinus) begin
         r.sign_seen = 1'b1;
         r.minus     = (c == i2e_pkg::CharMinus);
      end else if (!space) begin
         r.failed = 1'b1;
      end
      return r;
   endfunction

   assign full     = rec_full;
   assign accept   = push && !rec_full;
   assign rec_push = accept && last;

   // Apply the character, then close the text as if this were the last byte
   always_comb begin
      after_char = parse_ff;
      if (!parse_ff.finished && !parse_ff.failed) begin
         if (char_code == i2e_pkg::CharNul) begin
            after_char = end_text(parse_ff);
         end else begin
            after_char = consume(parse_ff, char_code);
         end
      end
      after_end = after_char;
      if (!after_char.finished && !after_char.failed) begin
         after_end = end_text(after_char);
      end
   end

   // Build the record for the converter
   always_comb begin
      rec.ok     = after_end.finished && !after_end.failed;
      rec.year   = after_end.year;
      rec.month  = after_end.month;
      rec.day    = after_end.day;
      rec.hour   = after_end.hour;
      rec.minute = after_end.minute;
      rec.second = after_end.second;
   end

   // Hold, advance, or clear after the last byte
   always_comb begin
      parse_in = parse_ff;
      if (accept) begin
         parse_in = last ? '0 : after_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff <= '0;
      end else begin
         parse_ff <= parse_in;
      end
   end

   `I2E_ASSERT_ALWAYS(a_front_fidx_range, clock, reset, parse_ff.fidx <= i2e_pkg::FieldSecond, "field index past seconds")
   `I2E_ASSERT_NEXT(a_front_clear_after_last, clock, reset, rec_push, parse_ff.fidx == i2e_pkg::FieldYear && !parse_ff.failed && !parse_ff.finished, "parser not cleared")

endmodule

>>> rtl/i2e_back.sv
// Converter pipeline: turns a parsed record into Unix seconds over six stages.
// Depends on i2e_pkg and the assertion macro header.
`include "iso8601_timestamp_to_epoch_core_macros.svh"

module i2e_back #(
   parameter int OutDepth = i2e_pkg::OutDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rec_empty,
   input  i2e_pkg::rec_type rec,
   output logic             rec_pop,
   output logic             res_push,
   output i2e_pkg::res_type res,
   input  logic             res_taken
);

   localparam int CntW = $clog2(OutDepth + 1);

   // Requests in flight or waiting at the output
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [5:0]      v_ff, v_in;

   // Stage 1
   logic        s1_ok_ff;
   logic [11:0] s1_y_ff;
   logic [24:0] s1_era_prod_ff;
   logic [10:0] s1_x_ff;
   logic [4:0]  s1_day_ff;
   logic [16:0] s1_h3600_ff;
   logic [11:0] s1_m60_ff;
   logic [5:0]  s1_sec_ff;
   // Stage 2
   logic        s2_ok_ff;
   logic [3:0]  s2_era_ff, s2_era_in;
   logic [8:0]  s2_yoe_ff, s2_yoe_in;
   logic [9:0]  s2_doy_ff, s2_doy_in;
   logic [16:0] s2_tod_ff, s2_tod_in;
   // Stage 3
   logic        s3_ok_ff;
   logic [17:0] s3_p365_ff, s3_p365_in;
   logic [1:0]  s3_q100_ff, s3_q100_in;
   logic [6:0]  s3_q4_ff;
   logic [21:0] s3_pera_ff, s3_pera_in;
   logic [9:0]  s3_doy_ff;
   logic [16:0] s3_tod_ff;
   // Stage 4
   logic        s4_ok_ff;
   logic [15:0] s4_days_ff, s4_days_in;
   logic [16:0] s4_tod_ff;
   // Stage 5
   logic        s5_ok_ff;
   logic [31:0] s5_dprod_ff, s5_dprod_in;
   logic [16:0] s5_tod_ff;
   // Stage 6
   i2e_pkg::res_type s6_res_ff, s6_res_in;

   // Stage 1 inputs
   logic        leap_adj;
   logic [11:0] y_adj;
   logic [3:0]  mp;

   assign rec_pop  = !rec_empty && (cnt_ff < CntW'(OutDepth));
   assign res_push = v_ff[5];
   assign res      = s6_res_ff;

   // Track credit for the output queue
   always_comb begin
      cnt_in = cnt_ff + CntW'(rec_pop) - CntW'(res_taken);
      v_in   = {v_ff[4:0], rec_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         v_ff   <= '0;
      end else begin
         cnt_ff <= cnt_in;
         v_ff   <= v_in;
      end
   end

   // Shift the year to start in March, take the era product and time-of-day parts
   always_comb begin
      leap_adj = (rec.month <= 4'd2);
      y_adj    = rec.year - 12'(leap_adj);
      mp       = leap_adj ? rec.month + 4'd9 : rec.month - 4'd3;
   end

   // Era, year of era, day of year, time of day
   always_comb begin
      s2_era_in = 4'(s1_era_prod_ff >> i2e_pkg::EraShift);
      s2_yoe_in = 9'(s1_y_ff - 12'(s2_era_in) * 12'(i2e_pkg::YearsPerEra));
      s2_doy_in = 10'(9'((23'(s1_x_ff) * 23'(i2e_pkg::RecipFive)) >> i2e_pkg::FiveShift))
                + 10'(s1_day_ff) - 10'd1;
      s2_tod_in = s1_h3600_ff + 17'(s1_m60_ff) + 17'(s1_sec_ff);
   end

   // Day-of-era parts
   always_comb begin
      s3_p365_in = 18'(s2_yoe_ff) * 18'(i2e_pkg::DaysPerYear);
      s3_q100_in = 2'((14'(s2_yoe_ff) * 14'(i2e_pkg::RecipCentury)) >> i2e_pkg::CenturyShift);
      s3_pera_in = 22'(s2_era_ff) * 22'(i2e_pkg::DaysPerEra);
   end

   // Days since the epoch
   always_comb begin
      s4_days_in = 16'(32'(s3_pera_ff) + 32'(s3_p365_ff) + 32'(s3_q4_ff) + 32'(s3_doy_ff)
                     - 32'(s3_q100_ff) - 32'(i2e_pkg::DaysEpochShift));
   end

   // Scale to seconds, then add the time of day
   always_comb begin
      s5_dprod_in             = 32'(33'(s4_days_ff) * 33'(i2e_pkg::SecPerDay));
      s6_res_in.valid_res     = s5_ok_ff;
      s6_res_in.epoch_seconds = s5_ok_ff ? s5_dprod_ff + 32'(s5_tod_ff) : '0;
   end

   // Advance the payload every cycle
   always_ff @(posedge clock) begin
      s1_ok_ff       <= rec.ok;
      s1_y_ff        <= y_adj;
      s1_era_prod_ff <= 25'(y_adj) * 25'(i2e_pkg::RecipEra);
      s1_x_ff        <= 11'(i2e_pkg::MarchDays) * 11'(mp) + 11'd2;
      s1_day_ff      <= rec.day;
      s1_h3600_ff    <= 17'(rec.hour) * 17'(i2e_pkg::SecPerHour);
      s1_m60_ff      <= 12'(rec.minute) * 12'(i2e_pkg::SecPerMin);
      s1_sec_ff      <= rec.second;

      s2_ok_ff  <= s1_ok_ff;
      s2_era_ff <= s2_era_in;
      s2_yoe_ff <= s2_yoe_in;
      s2_doy_ff <= s2_doy_in;
      s2_tod_ff <= s2_tod_in;

      s3_ok_ff   <= s2_ok_ff;
      s3_p365_ff <= s3_p365_in;
      s3_q100_ff <= s3_q100_in;
      s3_q4_ff   <= 7'(s2_yoe_ff >> 2);
      s3_pera_ff <= s3_pera_in;
      s3_doy_ff  <= s2_doy_ff;
      s3_tod_ff  <= s2_tod_ff;

      s4_ok_ff   <= s3_ok_ff;
      s4_days_ff <= s4_days_in;
      s4_tod_ff  <= s3_tod_ff;

      s5_ok_ff    <= s4_ok_ff;
      s5_dprod_ff <= s5_dprod_in;
      s5_tod_ff   <= s4_tod_ff;

      s6_res_ff <= s6_res_in;
   end

   `I2E_ASSERT_ALWAYS(a_back_credit_bound, clock, reset, cnt_ff <= CntW'(OutDepth), "credit overrun")
   `I2E_ASSERT_IMPLY(a_back_inflight_counted, clock, reset, v_ff != '0, cnt_ff != '0, "uncounted request in pipeline")

endmodule

>>> rtl/iso8601_timestamp_to_epoch_core.sv
// Top level of the ISO-8601 timestamp to Unix seconds converter.
// Depends on i2e_pkg, i2e_front, i2e_fifo and i2e_back.
//
// Feed the timestamp one byte per push; req_last marks the final byte, and a zero byte
// ends the text early. The parser takes one byte every cycle unless req_full is set, so
// strings stream back to back with no gap between them. The result of a string (Unix
// seconds, or zero with rsp_valid_res low) goes from the parser into a small request
// queue when its last byte is accepted, then through a six-stage conversion pipeline
// into the result queue. The converter issues a request only while the result queue
// (OutDepth entries) has room for everything in flight, so once the result side stops
// popping, req_full rises after the request queue (MidDepth entries) fills; with OutDepth
// at least eight the path sustains one result per cycle while the result side pops.
module iso8601_timestamp_to_epoch_core #(
   parameter int MidDepth = i2e_pkg::MidDepthDefault,
   parameter int OutDepth = i2e_pkg::OutDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_char_code,
   input  logic        req_last,
   input  logic        req_push,
   output logic        req_full,
   output logic [31:0] rsp_epoch_seconds,
   output logic        rsp_valid_res,
   output logic        rsp_empty,
   input  logic        rsp_pop
);

   localparam int RecW = $bits(i2e_pkg::rec_type);
   localparam int ResW = $bits(i2e_pkg::res_type);

   i2e_pkg::rec_type front_rec, back_rec;
   i2e_pkg::res_type back_res, out_res;
   logic             front_push, mid_full, mid_empty, back_pop;
   logic             res_push, res_taken, out_full;

   // Parse characters
   i2e_front u_front (
      .clock     (clock),
      .reset     (reset),
      .char_code (req_char_code),
      .last      (req_last),
      .push      (req_push),
      .full      (req_full),
      .rec_push  (front_push),
      .rec       (front_rec),
      .rec_full  (mid_full)
   );

   // Decouple parser from converter
   i2e_fifo #(
      .Width (RecW),
      .Depth (MidDepth)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_rec),
      .full      (mid_full),
      .pop       (back_pop),
      .pop_data  (back_rec),
      .empty     (mid_empty)
   );

   // Convert to seconds
   i2e_back #(
      .OutDepth (OutDepth)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_empty (mid_empty),
      .rec       (back_rec),
      .rec_pop   (back_pop),
      .res_push  (res_push),
      .res       (back_res),
      .res_taken (res_taken)
   );

   // Hold results until popped
   i2e_fifo #(
      .Width (ResW),
      .Depth (OutDepth)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (back_res),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_res),
      .empty     (rsp_empty)
   );

   assign res_taken         = rsp_pop && !rsp_empty;
   assign rsp_epoch_seconds = out_res.epoch_seconds;
   assign rsp_valid_res     = out_res.valid_res;

   `include "iso8601_timestamp_to_epoch_core_macros.svh"

   `I2E_ASSERT_IMPLY(a_top_out_room, clock, reset, res_push, !out_full, "result queue overflow")

endmodule

>>> tb/tb.sv
// Self-checking testbench for the ISO-8601 timestamp to Unix seconds converter.
// Depends on i2e_pkg and iso8601_timestamp_to_epoch_core; it predicts every result
// in place and compares it with what the converter pops from its result queue.
`timescale 1ns / 100ps

module tb;

   typedef struct packed {
      logic [31:0] secs;
      logic        ok;
   } stamp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [7:0]  req_char_code = '0;
   logic        req_last = 1'b0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [31:0] rsp_epoch_seconds;
   logic        rsp_valid_res;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;

   // Expected conversions, oldest first
   stamp_type stamps_due[$];
   stamp_type want;

   // Text under construction for the next request string
   logic [7:0] text_buf[$];

   // Parser shadow state
   logic [2:0]  fld;
   logic [11:0] acc;
   logic        neg, sign_seen, have_digit, bad, done;
   logic [11:0] yr;
   logic [3:0]  mo;
   logic [4:0]  dy, hr;
   logic [5:0]  mi, se;

   int error_count = 0;
   int bytes_sent = 0;
   int strings_sent = 0;
   int results_checked = 0;
   int valid_seen = 0;
   int burst_left = 0;
   bit steady = 1'b0;

   // Receiver stall pattern
   int pop_period = 1;
   int pop_duty = 1;
   int pop_phase = 0;
   int pattern_left = 0;

   iso8601_timestamp_to_epoch_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_char_code     (req_char_code),
      .req_last          (req_last),
      .req_push          (req_push),
      .req_full          (req_full),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_valid_res     (rsp_valid_res),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_error(input string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------- prediction

   function automatic void clear_number();
      acc = '0;
      neg = 1'b0;
      sign_seen = 1'b0;
      have_digit = 1'b0;
   endfunction

   function automatic void clear_parse();
      clear_number();
      fld = i2e_pkg::FieldYear;
      bad = 1'b0;
      done = 1'b0;
      yr = '0;
      mo = '0;
      dy = '0;
      hr = '0;
      mi = '0;
      se = '0;
   endfunction

   // Store the finished number in its field and range check it
   function automatic void commit_field();
      logic [11:0] lo, hi;
      lo = '0;
      hi = '0;
      if (neg && acc != 0) bad = 1'b1;
      case (fld)
         i2e_pkg::FieldYear: begin
            yr = acc;      lo = i2e_pkg::YearMin;  hi = i2e_pkg::YearMax;
         end
         i2e_pkg::FieldMonth: begin
            mo = acc[3:0]; lo = i2e_pkg::MonthMin; hi = i2e_pkg::MonthMax;
         end
         i2e_pkg::FieldDay: begin
            dy = acc[4:0]; lo = i2e_pkg::DayMin;   hi = i2e_pkg::DayMax;
         end
         i2e_pkg::FieldHour: begin
            hr = acc[4:0]; lo = '0;                hi = i2e_pkg::HourMax;
         end
         i2e_pkg::FieldMinute: begin
            mi = acc[5:0]; lo = '0;                hi = i2e_pkg::MinuteMax;
         end
         i2e_pkg::FieldSecond: begin
            se = acc[5:0]; lo = '0;                hi = i2e_pkg::SecondMax;
         end
         default: begin
            bad = 1'b1;
            return;
         end
      endcase
      if (acc < lo || acc > hi) bad = 1'b1;
   endfunction

   function automatic void end_of_text();
      if (fld == i2e_pkg::FieldSecond && have_digit) begin
         commit_field();
         done = 1'b1;
      end else begin
         bad = 1'b1;
      end
   endfunction

   // Advance the shadow parser by one character
   function automatic void step_char(input logic [7:0] c);
      logic       digit;
      logic [7:0] sep;
      int         n;
      digit = (c >= i2e_pkg::CharZero && c <= i2e_pkg::CharNine);
      if (have_digit) begin
         if (digit) begin
            n = int'(acc) * 10 + int'(c - i2e_pkg::CharZero);
            acc = (n > int'(i2e_pkg::AccMax)) ? i2e_pkg::AccMax : 12'(n);
            return;
         end
         commit_field();
         if (bad) return;
         if (fld == i2e_pkg::FieldSecond) begin
            done = 1'b1;
            return;
         end
         case (fld)
            i2e_pkg::FieldYear, i2e_pkg::FieldMonth:  sep = i2e_pkg::CharMinus;
            i2e_pkg::FieldDay:                        sep = i2e_pkg::CharT;
            i2e_pkg::FieldHour, i2e_pkg::FieldMinute: sep = i2e_pkg::CharColon;
            default:                                  sep = i2e_pkg::CharNul;
         endcase
         if (c == sep) begin
            fld = fld + 3'd1;
            clear_number();
         end else begin
            bad = 1'b1;
         end
      end else if (digit) begin
         have_digit = 1'b1;
         acc = 12'(c - i2e_pkg::CharZero);
      end else if (sign_seen) begin
         bad = 1'b1;
      end else if (c == i2e_pkg::CharPlus || c == i2e_pkg::CharMinus) begin
         sign_seen = 1'b1;
         neg = (c == i2e_pkg::CharMinus);
      end else if (!(c == i2e_pkg::CharSpace ||
                     (c >= i2e_pkg::CharTab && c <= i2e_pkg::CharCr))) begin
         bad = 1'b1;
      end
   endfunction

   // Take one accepted request; on the last byte queue the expected conversion
   function automatic void take_char(input logic [7:0] c, input logic l);
      longint y, m, era, yoe, mp, doy, doe, days, secs;
      stamp_type r;
      if (!done && !bad) begin
         if (c == i2e_pkg::CharNul) end_of_text();
         else step_char(c);
      end
      if (!l) return;
      if (!done && !bad) end_of_text();
      r.ok = done && !bad;
      r.secs = '0;
      if (r.ok) begin
         // Days from the civil date, with March as the first month of the year
         y = longint'(yr);
         m = longint'(mo);
         if (m <= 2) y = y - 1;
         era = y / longint'(i2e_pkg::YearsPerEra);
         yoe = y - era * longint'(i2e_pkg::YearsPerEra);
         mp = (m > 2) ? m - 3 : m + 9;
         doy = (longint'(i2e_pkg::MarchDays) * mp + 2) / 5 + longint'(dy) - 1;
         doe = yoe * longint'(i2e_pkg::DaysPerYear) + yoe / 4 - yoe / 100 + doy;
         days = era * longint'(i2e_pkg::DaysPerEra) + doe
              - longint'(i2e_pkg::DaysEpochShift);
         secs = days * longint'(i2e_pkg::SecPerDay)
              + longint'(hr) * longint'(i2e_pkg::SecPerHour)
              + longint'(mi) * longint'(i2e_pkg::SecPerMin) + longint'(se);
         r.secs = secs[31:0];
      end
      stamps_due.push_back(r);
      clear_parse();
   endfunction

   // ---------------------------------------------------------------- result side

   // Check each popped result, then pick the next pop decision
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         results_checked++;
         if (rsp_valid_res) valid_seen++;
         if (stamps_due.size() == 0) begin
            report_error($sformatf("result with none expected: secs=%0d valid=%0b",
                                   rsp_epoch_seconds, rsp_valid_res));
         end else begin
            want = stamps_due.pop_front();
            if (rsp_valid_res !== want.ok)
               report_error($sformatf("result %0d valid_res: expected %0b, got %0b",
                                      results_checked, want.ok, rsp_valid_res));
            if (rsp_epoch_seconds !== want.secs)
               report_error($sformatf("result %0d epoch_seconds: expected %0d, got %0d",
                                      results_checked, want.secs, rsp_epoch_seconds));
         end
      end
      if (pattern_left == 0) begin
         pop_period = $urandom_range(1, 12);
         pop_duty = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, pop_period);
         pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      pop_phase = (pop_phase + 1) % pop_period;
      rsp_pop <= steady || (pop_phase < pop_duty);
   end

   // ---------------------------------------------------------------- request side

   // Send one byte, with random gaps between bursts
   task automatic send_byte(input logic [7:0] c, input logic l);
      int gap;
      if (burst_left == 0) begin
         gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_char_code <= c;
      req_last <= l;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      take_char(c, l);
      bytes_sent++;
   endtask

   // Send the text buffer as one string, last flag on its final byte
   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++)
         send_byte(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
      strings_sent++;
   endtask

   function automatic void append_str(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   task automatic send_stamp(input string s, input bit nul);
      append_str(s);
      if (nul) text_buf.push_back(i2e_pkg::CharNul);
      send_text();
   endtask

   // Hold off the sender until every expected result has come back
   task automatic drain();
      req_push <= 1'b0;
      while (stamps_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Mostly in range, sometimes just outside or far too long
   function automatic int pick_value(input int lo, input int hi);
      case ($urandom_range(0, 19))
         0:       return (lo > 0) ? lo - 1 : hi + 1;
         1:       return hi + 1;
         2:       return $urandom_range(0, 99999);
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   // Append a number with optional whitespace, sign and leading zeros
   function automatic void append_number(input int v);
      int r;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            r = $urandom_range(0, 5);
            text_buf.push_back((r == 5) ? i2e_pkg::CharSpace : 8'(i2e_pkg::CharTab + r));
         end
      end
      if ($urandom_range(0, 11) == 0)
         text_buf.push_back(($urandom_range(0, 2) == 0) ? i2e_pkg::CharMinus
                                                         : i2e_pkg::CharPlus);
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3)) text_buf.push_back(i2e_pkg::CharZero);
      append_str($sformatf("%0d", v));
   endfunction

   // Build one timestamp with random content, ending and damage
   function automatic void build_stamp();
      int pos;
      append_number(pick_value(2020, 2099));
      text_buf.push_back(i2e_pkg::CharMinus);
      append_number(pick_value(1, 12));
      text_buf.push_back(i2e_pkg::CharMinus);
      append_number(pick_value(1, 31));
      text_buf.push_back(i2e_pkg::CharT);
      append_number(pick_value(0, 23));
      text_buf.push_back(i2e_pkg::CharColon);
      append_number(pick_value(0, 59));
      text_buf.push_back(i2e_pkg::CharColon);
      append_number(pick_value(0, 60));
      case ($urandom_range(0, 3))
         0: ;
         1: text_buf.push_back(i2e_pkg::CharNul);
         2: begin
            text_buf.push_back(i2e_pkg::CharNul);
            repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            append_str(($urandom_range(0, 1) == 0) ? "Z" : ".123Z");
            if ($urandom_range(0, 1) == 0) text_buf.push_back(i2e_pkg::CharNul);
         end
      endcase
      if ($urandom_range(0, 4) == 0) begin
         pos = $urandom_range(0, text_buf.size() - 1);
         case ($urandom_range(0, 3))
            0: text_buf[pos] = 8'($urandom_range(0, 255));
            1: while (text_buf.size() > pos + 1) void'(text_buf.pop_back());
            2: text_buf.insert(pos, 8'($urandom_range(0, 255)));
            default: if (text_buf.size() > 1) text_buf.delete(pos);
         endcase
      end
   endfunction

   // ---------------------------------------------------------------- tests

   // Boundaries of every field, both ways of ending the text
   task automatic test_field_limits();
      send_stamp("2020-01-01T00:00:00", 1'b0);
      send_stamp("2099-12-31T23:59:60", 1'b1);
      send_stamp("2019-12-31T23:59:59", 1'b1);
      send_stamp("2100-01-01T00:00:00", 1'b0);
      send_stamp("2024-00-10T10:10:10", 1'b1);
      send_stamp("2024-13-10T10:10:10", 1'b1);
      send_stamp("2024-02-32T10:10:10", 1'b1);
      send_stamp("2024-03-00T10:10:10", 1'b1);
      send_stamp("2024-05-05T24:00:00", 1'b1);
      send_stamp("2024-05-05T23:60:00", 1'b1);
      send_stamp("2024-05-05T23:59:61", 1'b1);
   endtask

   // Whitespace, signs, minus zero, leading zeros and overlong numbers
   task automatic test_number_syntax();
      send_stamp(" \t2024-+3-\n7T-0:05: 9", 1'b1);
      send_stamp("2024-03-07T12:30:000000045", 1'b1);
      send_stamp("99999-03-07T12:30:45", 1'b1);
      send_stamp("2024-03-07T12:30:99999", 1'b0);
      send_stamp("+-2024-01-01T00:00:00", 1'b1);
      send_stamp("- 2024-01-01T00:00:00", 1'b1);
      send_stamp("2024--5-01T00:00:00", 1'b1);
   endtask

   // Empty text, early end, wrong separators and trailing bytes
   task automatic test_text_endings();
      text_buf.push_back(i2e_pkg::CharNul);
      send_text();
      send_stamp("2024-01-01T12:30", 1'b1);
      send_stamp("2024-01-01T12:30:", 1'b1);
      send_stamp("2024-01-01T12:30:+", 1'b0);
      send_stamp("2024/01/01T12:30:45", 1'b1);
      send_stamp("2024-01-01 12:30:45", 1'b1);
      send_stamp("2024-02-29T12:00:00Z+junk", 1'b0);
      append_str("2024-01-01T12:30:45");
      text_buf.push_back(i2e_pkg::CharNul);
      send_stamp("xy", 1'b0);
      text_buf.push_back(8'hFF);
      send_stamp("2024-01-01T12:30:45", 1'b1);
   endtask

   // Valid strings with no gaps on either side
   task automatic test_back_to_back();
      steady = 1'b1;
      repeat (8) begin
         append_str($sformatf("%0d-%02d-%02dT%02d:%02d:%02d",
                              $urandom_range(2020, 2099), $urandom_range(1, 12),
                              $urandom_range(1, 31), $urandom_range(0, 23),
                              $urandom_range(0, 59), $urandom_range(0, 60)));
         send_text();
      end
      steady = 1'b0;
      drain();
   endtask

   // Mostly well-formed timestamps, some damaged, some short noise, up to the byte budget
   task automatic test_random_stamps();
      int stop_at;
      stop_at = 1150;
      while (bytes_sent < stop_at) begin
         steady = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_stamp();
         end
         send_text();
         if ($urandom_range(0, 39) == 0) drain();
      end
      steady = 1'b0;
   endtask

   initial begin
      clear_parse();
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_field_limits();
      test_number_syntax();
      test_text_endings();
      drain();
      test_back_to_back();
      test_random_stamps();

      // Wait for the last conversions to come out
      req_push <= 1'b0;
      while (stamps_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d strings in %0d bytes: field limits, number syntax, text endings,",
               strings_sent, bytes_sent);
      $display("back-to-back and random stamps; checked %0d results, %0d of them valid",
               results_checked, valid_seen);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/i2e_pkg.sv
rtl/i2e_fifo.sv
rtl/i2e_front.sv
rtl/i2e_back.sv
rtl/iso8601_timestamp_to_epoch_core.sv
tb/tb.sv
